@@ rtl/eeb_pkg.sv @@
`default_nettype none

package eeb_pkg;

   // Coefficient width; operands and the divisor are one bit narrower.
   localparam int DATA_W = 32;
   localparam int OPND_W = DATA_W - 1;

   // Quotient stack depth and the widths that follow from it.
   localparam int QSTACK_DEPTH = 2 * DATA_W + 2;
   localparam int QIDX_W       = $clog2(QSTACK_DEPTH);
   localparam int QCNT_W       = $clog2(QSTACK_DEPTH + 1);

   // Divider step counter.
   localparam int DCNT_W = $clog2(OPND_W);

   typedef logic [OPND_W-1:0] opnd_type;
   typedef logic [DATA_W-1:0] coeff_type;
   typedef logic [QIDX_W-1:0] qidx_type;
   typedef logic [QCNT_W-1:0] qcnt_type;

   // Handshake between the sequencer and the divider.
   typedef struct packed {
      logic     start;
      opnd_type dividend;
      opnd_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      opnd_type quotient;
      opnd_type remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/eeb_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module eeb_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eeb_pkg::div_req_type div_req,
   output eeb_pkg::div_rsp_type      div_rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [eeb_pkg::DCNT_W-1:0] count_ff, count_in;
   eeb_pkg::opnd_type          rem_ff, rem_in;
   eeb_pkg::opnd_type          quo_ff, quo_in;
   eeb_pkg::opnd_type          dvs_ff, dvs_in;
   logic [eeb_pkg::OPND_W:0]   shifted;
   logic [eeb_pkg::OPND_W+1:0] diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[eeb_pkg::OPND_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = eeb_pkg::DCNT_W'(eeb_pkg::OPND_W - 1);
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         // The trial remainder stays below twice the divisor.
         rem_in = diff[eeb_pkg::OPND_W+1] ? shifted[eeb_pkg::OPND_W-1:0]
                                          : diff[eeb_pkg::OPND_W-1:0];
         quo_in = {quo_ff[eeb_pkg::OPND_W-2:0], ~diff[eeb_pkg::OPND_W+1]};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/eeb_qstack.sv @@
`default_nettype none

// Quotient stack storage: one write port, one registered read port.
module eeb_qstack (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire eeb_pkg::qidx_type wr_addr,
   input  wire eeb_pkg::opnd_type wr_data,
   input  wire eeb_pkg::qidx_type rd_addr,
   output eeb_pkg::opnd_type      rd_data
);

   eeb_pkg::opnd_type quot_mem [eeb_pkg::QSTACK_DEPTH];
   eeb_pkg::opnd_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         quot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= quot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/extended_euclid_bezout.sv @@
// Each quotient step runs on the single one-bit-per-cycle divider, and
// each unwind step passes through stack read, multiply, subtract and check.
// One item at a time: the next request is taken only once the sequencer is back in idle,
// which is delayed while a held result keeps the finished item from leaving.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
`default_nettype none

module extended_euclid_bezout (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [eeb_pkg::OPND_W-1:0]     req_operand_a,
   input  wire logic [eeb_pkg::OPND_W-1:0]     req_operand_b,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [eeb_pkg::OPND_W-1:0]          rsp_divisor,
   output logic signed [eeb_pkg::DATA_W-1:0]   rsp_coeff_a,
   output logic signed [eeb_pkg::DATA_W-1:0]   rsp_coeff_b
);

   // The sequencer runs two passes. The forward pass feeds (rb, ra) to the
   // divider, pushes each quotient onto the stack and replaces the pair
   // by (ra, rb mod ra) until ra is zero. The backward pass pops the quotients
   // in reverse order and rebuilds the coefficients with x' = y - q*x, y' = x.
   // All coefficient arithmetic wraps at the coefficient width, which is exact
   // because the true coefficients always fit.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_WAIT,
      ST_UNWIND,
      ST_POP,
      ST_MUL,
      ST_SUB
   } state_type;

   state_type             state_ff, state_in;
   eeb_pkg::opnd_type     ra_ff, ra_in;
   eeb_pkg::opnd_type     rb_ff, rb_in;
   eeb_pkg::coeff_type    x_ff, x_in;
   eeb_pkg::coeff_type    y_ff, y_in;
   eeb_pkg::coeff_type    prod_ff, prod_in;
   eeb_pkg::qcnt_type     depth_ff, depth_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   eeb_pkg::opnd_type     rsp_divisor_ff, rsp_divisor_in;
   eeb_pkg::coeff_type    rsp_coeff_a_ff, rsp_coeff_a_in;
   eeb_pkg::coeff_type    rsp_coeff_b_ff, rsp_coeff_b_in;

   eeb_pkg::div_req_type  div_req;
   eeb_pkg::div_rsp_type  div_rsp;
   logic                  push_en;
   eeb_pkg::qcnt_type     depth_dec;
   eeb_pkg::opnd_type     quot_rd;
   logic                  req_xfer;
   logic                  rsp_xfer;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign depth_dec = depth_ff - 1'b1;

   // The divider is started straight from the check state whenever another
   // quotient is due, so it sees the operand registers as they stand.
   assign div_req.start    = (state_ff == ST_CHECK) && (ra_ff != '0) &&
                             (depth_ff < eeb_pkg::QCNT_W'(eeb_pkg::QSTACK_DEPTH));
   assign div_req.dividend = rb_ff;
   assign div_req.divisor  = ra_ff;

   assign push_en = (state_ff == ST_DIV_WAIT) && div_rsp.done;

   eeb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Writes go to the current depth; the pop state reads the top entry, and
   // the registered data is ready in the multiply state.
   eeb_qstack u_qstack (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (depth_ff[eeb_pkg::QIDX_W-1:0]),
      .wr_data (div_rsp.quotient),
      .rd_addr (depth_dec[eeb_pkg::QIDX_W-1:0]),
      .rd_data (quot_rd)
   );

   always_comb begin
      state_in       = state_ff;
      ra_in          = ra_ff;
      rb_in          = rb_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      prod_in        = prod_ff;
      depth_in       = depth_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_xfer;
      rsp_divisor_in = rsp_divisor_ff;
      rsp_coeff_a_in = rsp_coeff_a_ff;
      rsp_coeff_b_in = rsp_coeff_b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ra_in    = req_operand_a;
               rb_in    = req_operand_b;
               x_in     = '0;
               y_in     = eeb_pkg::DATA_W'(1);
               depth_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (div_req.start) begin
               state_in = ST_DIV_WAIT;
            end else begin
               state_in = ST_UNWIND;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               rb_in    = ra_ff;
               ra_in    = div_rsp.remainder;
               depth_in = depth_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_UNWIND: begin
            if (depth_ff != '0) begin
               state_in = ST_POP;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               // The output register is free (or empties this cycle).
               rsp_valid_in   = 1'b1;
               rsp_divisor_in = rb_ff;
               rsp_coeff_a_in = x_ff;
               rsp_coeff_b_in = y_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_POP: begin
            depth_in = depth_dec;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = {1'b0, quot_rd} * x_ff;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            x_in     = y_ff - prod_ff;
            y_in     = x_ff;
            state_in = ST_UNWIND;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         depth_ff     <= depth_in;
      end
      ra_ff          <= ra_in;
      rb_ff          <= rb_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      prod_ff        <= prod_in;
      rsp_divisor_ff <= rsp_divisor_in;
      rsp_coeff_a_ff <= rsp_coeff_a_in;
      rsp_coeff_b_ff <= rsp_coeff_b_in;
   end

   // A new request is taken only while the sequencer is idle; a finished
   // result may still be waiting in the output register at that time.
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;
   assign rsp_coeff_a = $signed(rsp_coeff_a_ff);
   assign rsp_coeff_b = $signed(rsp_coeff_b_ff);

endmodule

`default_nettype wire

@@ tb/bezout_checker.sv @@
module bezout_checker
   import eeb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [OPND_W-1:0]     req_operand_a,
   input  wire logic [OPND_W-1:0]     req_operand_b,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [OPND_W-1:0]     rsp_divisor,
   input  wire logic signed [DATA_W-1:0] rsp_coeff_a,
   input  wire logic signed [DATA_W-1:0] rsp_coeff_b,
   output int                         outstanding,
   output int                         failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_MAX = 2 * DATA_W + 2;
   localparam int SHOWN_MAX = 10;

   typedef struct {
      opnd_type  operand_a;
      opnd_type  operand_b;
      opnd_type  divisor;
      coeff_type coeff_a;
      coeff_type coeff_b;
   } answer_type;

   answer_type pending_answers[$];
   answer_type oldest;

   // Forward pass collects the quotients, backward pass rebuilds x and y
   // with 64-bit wrapping arithmetic, as the recursive definition does.
   function automatic answer_type bezout_solve(opnd_type a_in, opnd_type b_in);
      logic [63:0] quot_stack [STACK_MAX];
      logic [63:0] ra, rb, rem, x, y, nx;
      int depth;
      answer_type ans;
      ra = 64'(a_in);
      rb = 64'(b_in);
      x = 64'd0;
      y = 64'd1;
      depth = 0;
      while (ra != 64'd0 && depth < STACK_MAX) begin
         rem = rb % ra;
         quot_stack[depth] = rb / ra;
         rb = ra;
         ra = rem;
         depth++;
      end
      while (depth > 0) begin
         depth--;
         nx = y - quot_stack[depth] * x;
         y = x;
         x = nx;
      end
      ans.operand_a = a_in;
      ans.operand_b = b_in;
      ans.divisor = rb[OPND_W-1:0];
      ans.coeff_a = x[DATA_W-1:0];
      ans.coeff_b = y[DATA_W-1:0];
      return ans;
   endfunction

   task automatic count_failure(input string why);
      failures++;
      if (failures <= SHOWN_MAX) begin
         $display("%t checker: %s", $realtime, why);
      end
   endtask

   initial begin
      failures = 0;
      outstanding = 0;
   end

   // A result transfer is matched before a request transfer at the same edge
   // is queued, so a result can never be paired with its own request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               count_failure($sformatf("unexpected result divisor=%0d coeff_a=%0d coeff_b=%0d",
                                       rsp_divisor, rsp_coeff_a, rsp_coeff_b));
            end else begin
               oldest = pending_answers.pop_front();
               if (rsp_divisor !== oldest.divisor || rsp_coeff_a !== oldest.coeff_a ||
                   rsp_coeff_b !== oldest.coeff_b) begin
                  count_failure($sformatf(
                     "a=%0d b=%0d expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                     oldest.operand_a, oldest.operand_b, oldest.divisor,
                     $signed(oldest.coeff_a), $signed(oldest.coeff_b),
                     rsp_divisor, rsp_coeff_a, rsp_coeff_b));
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_answers = {pending_answers, bezout_solve(req_operand_a, req_operand_b)};
         end
         outstanding <= pending_answers.size();
      end
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import eeb_pkg::*;

   // Number of random operand pairs after the directed part.
   localparam int RANDOM_ITEMS = 400;
   // Length of the one long result hold-off, in cycles. It is longer than the
   // slowest item, so the block finishes one item and keeps its result waiting;
   // the next item then cannot leave, and the requests behind it are stalled.
   localparam int LONG_HOLD = 3000;
   // Quiet time after the last result: more than the worst-case latency of an
   // item, so a stray result would still show up.
   localparam int TAIL_CYCLES = 2000;
   localparam opnd_type OPND_MAX = '1;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   opnd_type  req_operand_a = '0;
   opnd_type  req_operand_b = '0;
   logic      rsp_stall = 1'b0;
   logic      req_stall;
   logic      rsp_valid;
   opnd_type  rsp_divisor;
   coeff_type rsp_coeff_a;
   coeff_type rsp_coeff_b;

   int outstanding;
   int failures;

   // Set by the stimulus to ask the receiver for its long hold-off; the
   // receiver clears it when it starts holding.
   bit hold_request = 1'b0;
   // Remaining transfers of a back-to-back burst on the request side.
   int burst_left = 0;

   always #5 clock = ~clock;

   extended_euclid_bezout dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_divisor   (rsp_divisor),
      .rsp_coeff_a   (rsp_coeff_a),
      .rsp_coeff_b   (rsp_coeff_b)
   );

   bezout_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_divisor   (rsp_divisor),
      .rsp_coeff_a   (rsp_coeff_a),
      .rsp_coeff_b   (rsp_coeff_b),
      .outstanding   (outstanding),
      .failures      (failures)
   );

   // Idle length shared by both sides: mostly none or a few cycles, now and
   // then a long gap that overlaps a good part of an item's division work.
   function automatic int idle_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 20);
      end
      return $urandom_range(40, 300);
   endfunction

   // Sender gaps: idle_len, except inside a burst where requests follow
   // each other with no gap at all.
   function automatic int sender_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(99) < 5) begin
         burst_left = $urandom_range(5, 20);
         return 0;
      end
      return idle_len();
   endfunction

   // Fibonacci numbers: consecutive ones take the most quotient steps and
   // give the largest coefficients. fib(46) is the last that fits 31 bits.
   function automatic opnd_type fib(int n);
      longint unsigned p, q, t;
      p = 0;
      q = 1;
      repeat (n) begin
         t = p + q;
         p = q;
         q = t;
      end
      return opnd_type'(p);
   endfunction

   // Offers one operand pair and returns after its transfer and gap. The
   // payload is held while the block stalls. With no gap the next pair is
   // put on the port directly, so valid is never lowered and raised in the
   // same step.
   task automatic send_pair(input opnd_type a, input opnd_type b);
      int gap;
      req_valid <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Sender pause: nothing is offered until every expected result has come.
   // The first edge lets the checker count the last transfer.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   // Random operand pairs. Full-width pairs dominate; the rest aim at the
   // interesting corners: tiny values, zero operands, deep Fibonacci chains,
   // a large common factor and one operand a multiple of the other.
   task automatic draw_pair(output opnd_type a, output opnd_type b);
      int unsigned pick, g, m, n;
      opnd_type t;
      pick = $urandom_range(99);
      if (pick < 45) begin
         a = opnd_type'($urandom);
         b = opnd_type'($urandom);
      end else if (pick < 65) begin
         a = opnd_type'($urandom_range(255));
         b = opnd_type'($urandom_range(255));
      end else if (pick < 77) begin
         n = $urandom_range(30, 45);
         a = fib(int'(n));
         b = fib(int'(n + 1));
      end else if (pick < 89) begin
         g = $urandom_range(1, 65535);
         m = $urandom_range(0, 32767);
         n = $urandom_range(0, 32767);
         a = opnd_type'(g * m);
         b = opnd_type'(g * n);
      end else if (pick < 95) begin
         a = opnd_type'($urandom);
         b = ($urandom_range(1) == 0) ? '0 : a;
      end else begin
         g = $urandom_range(1, 65535);
         m = $urandom_range(0, 32767);
         a = opnd_type'(g * m);
         b = opnd_type'(g);
      end
      if ($urandom_range(1) == 1) begin
         t = a;
         a = b;
         b = t;
      end
   endtask

   // Hard limit: far beyond the slowest correct run, with every item at its
   // deepest chain and the longest gaps and stalls on both sides.
   initial begin
      #40_000_000;
      $display("extended_euclid_bezout test failed");
      $finish;
   end

   // Result side. Stall and release alternate in random spans, with quiet
   // stretches of no stall at all, and once the long hold-off that the
   // stimulus asks for, counted here in cycles.
   initial begin
      int unsigned r;
      int span;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         r = $urandom_range(99);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            span = LONG_HOLD;
         end else if (r < 10) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(200, 2000);
         end else if (r < 45) begin
            rsp_stall <= 1'b1;
            span = 1 + idle_len();
         end else begin
            rsp_stall <= 1'b0;
            span = 1 + idle_len();
         end
         repeat (span) @(posedge clock);
      end
   end

   // Request side and verdict.
   initial begin
      opnd_type a, b;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Zero operands; a zero first operand skips the divider entirely.
      send_pair('0, '0);
      send_pair('0, OPND_MAX);
      send_pair(OPND_MAX, '0);
      send_pair('0, opnd_type'(1));
      send_pair(opnd_type'(1), '0);
      // Units and the largest operands, equal and adjacent.
      send_pair(opnd_type'(1), opnd_type'(1));
      send_pair(OPND_MAX, OPND_MAX);
      send_pair(opnd_type'(1), OPND_MAX);
      send_pair(OPND_MAX, opnd_type'(1));
      send_pair(OPND_MAX, OPND_MAX - 1'b1);
      send_pair(OPND_MAX - 1'b1, OPND_MAX);
      // Longest chain that fits the operand width, in both orders.
      send_pair(fib(45), fib(46));
      send_pair(fib(46), fib(45));
      // Small textbook pairs with coefficients of both signs.
      send_pair(opnd_type'(240), opnd_type'(46));
      send_pair(opnd_type'(46), opnd_type'(240));
      send_pair(opnd_type'(12), opnd_type'(18));
      // Powers of two, alternating bit patterns and two large primes.
      send_pair(31'h4000_0000, 31'h3000_0000);
      send_pair(31'h5555_5555, 31'h2AAA_AAAA);
      send_pair(31'h2AAA_AAAA, 31'h5555_5555);
      send_pair(opnd_type'(1000000007), opnd_type'(998244353));

      // Let the block run empty, then ask for the long hold-off while
      // requests keep coming, so the input side has to stall.
      drain_results();
      hold_request = 1'b1;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            drain_results();
         end
         draw_pair(a, b);
         send_pair(a, b);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("extended_euclid_bezout test passed");
      end else begin
         $display("extended_euclid_bezout test failed");
      end
      $finish;
   end

endmodule
